// File: rtl/srf_pkg.sv
// shared constants, types and helpers for the selective-repeat frame builder
// no dependencies; imported by srf_ctrl, srf_dpath and the top level, not by srf_ram

package srf_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int SEQ_BITS   = 16;
  localparam int SLOT_AW    = $clog2(MAX_WINDOW);
  localparam int CNT_W      = SLOT_AW + 1;
  localparam int NNS_W      = SEQ_BITS + 1;
  localparam int LOSS_W     = 32;
  localparam int WIN_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [WIN_W-1:0]    WINDOW_RESET = WIN_W'(4);
  localparam logic [SEQ_BITS-1:0] TOTAL_RESET  = SEQ_BITS'(20);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIZE   = 1'b0,
    REG_TOTAL_PACKETS = 1'b1
  } cfg_reg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic emit_re;
    logic emit_new;
    logic emit_done;
    logic commit;
  } srf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rem_any;
    logic rd_v;
    logic fresh_ok;
    logic fresh_last;
    logic cnt_zero;
  } srf_stat_t;

  // index of lowest set bit
  function automatic logic [SLOT_AW-1:0] low_index(input logic [LOSS_W-1:0] v);
    logic [SLOT_AW-1:0] idx;
    idx = '0;
    for (int k = LOSS_W - 1; k >= 0; k--) begin
      if (v[k]) idx = SLOT_AW'(k);
    end
    return idx;
  endfunction

endpackage

// File: rtl/srf_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module srf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// File: rtl/srf_ctrl.sv
// controller fsm: sequences resend scan, fresh fill and done beat
// depends on srf_pkg

module srf_ctrl
  import srf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  srf_stat_t stat,
  output srf_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESEND,
    S_FRESH,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_RESEND;
        end
      end
      S_RESEND: begin
        cmd.scan    = stat.rem_any;
        cmd.emit_re = stat.rd_v;
        if (!stat.rem_any && !stat.rd_v) begin
          priority if (stat.fresh_ok) begin
            state_nxt = S_FRESH;
          end else if (stat.cnt_zero) begin
            state_nxt = S_DONE;
          end else begin
            cmd.commit = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      S_FRESH: begin
        cmd.emit_new = 1'b1;
        if (stat.fresh_last) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_DONE: begin
        cmd.emit_done = 1'b1;
        cmd.commit    = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/srf_dpath.sv
// datapath: config registers, frame slot store, counters, result beat
// depends on srf_pkg and srf_ram

module srf_dpath
  import srf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [LOSS_W-1:0]     in_loss_map,
  input  srf_cmd_t              cmd,
  output srf_stat_t             stat,
  output logic                  out_valid,
  output logic [SEQ_BITS-1:0]   out_seq_number,
  output logic                  out_is_retransmit,
  output logic                  out_all_done,
  output logic                  out_last_in_frame
);

  logic [WIN_W-1:0]    win_r;
  logic [SEQ_BITS-1:0] total_r;
  logic [CNT_W-1:0]    frame_len_r;
  logic [NNS_W-1:0]    nns_r, nns_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [LOSS_W-1:0]   rem_r, rem_nxt;
  logic                rd_v_r;

  logic [WIN_W-1:0]    win_eff;
  logic [LOSS_W-1:0]   len_mask;
  logic [SLOT_AW-1:0]  scan_idx;
  logic [SEQ_BITS-1:0] ram_rdata;
  logic                ram_we;
  logic [SEQ_BITS-1:0] ram_wdata;
  logic                room_after;

  always_comb begin
    priority if (win_r == '0) win_eff = WIN_W'(1);
    else if (win_r > WIN_W'(MAX_WINDOW)) win_eff = WIN_W'(MAX_WINDOW);
    else win_eff = win_r;
  end

  assign len_mask = LOSS_W'((33'd1 << frame_len_r) - 33'd1);
  assign scan_idx = low_index(rem_r);

  // room for one more slot after the current one
  assign room_after = ({1'b0, count_r} + (CNT_W + 1)'(1)) < (CNT_W + 1)'(win_eff);

  assign stat.rem_any    = (rem_r != '0);
  assign stat.rd_v       = rd_v_r;
  assign stat.fresh_ok   = ({1'b0, count_r} < (CNT_W + 1)'(win_eff))
                         && (nns_r < NNS_W'(total_r));
  assign stat.fresh_last = !(room_after && ((nns_r + NNS_W'(1)) < NNS_W'(total_r)));
  assign stat.cnt_zero   = (count_r == '0);

  always_comb begin
    rem_nxt   = rem_r;
    count_nxt = count_r;
    nns_nxt   = nns_r;
    if (cmd.load) begin
      rem_nxt   = in_loss_map & len_mask;
      count_nxt = '0;
    end
    if (cmd.scan) rem_nxt = rem_r & ~(LOSS_W'(1) << scan_idx);
    if (cmd.emit_re || cmd.emit_new) count_nxt = count_r + CNT_W'(1);
    if (cmd.emit_new) nns_nxt = nns_r + NNS_W'(1);
  end

  assign ram_we    = cmd.emit_re || cmd.emit_new;
  assign ram_wdata = cmd.emit_re ? ram_rdata : nns_r[SEQ_BITS-1:0];

  srf_ram #(
    .WIDTH(SEQ_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[SLOT_AW-1:0]),
    .wdata(ram_wdata),
    .re   (cmd.scan),
    .raddr(scan_idx),
    .rdata(ram_rdata)
  );

  always_comb begin
    out_valid         = cmd.emit_re || cmd.emit_new || cmd.emit_done;
    out_seq_number    = '0;
    out_is_retransmit = 1'b0;
    out_all_done      = 1'b0;
    out_last_in_frame = 1'b0;
    if (cmd.emit_re) begin
      out_seq_number    = ram_rdata;
      out_is_retransmit = 1'b1;
      out_last_in_frame = !stat.rem_any
                        && !(room_after && (nns_r < NNS_W'(total_r)));
    end else if (cmd.emit_new) begin
      out_seq_number    = nns_r[SEQ_BITS-1:0];
      out_last_in_frame = stat.fresh_last;
    end else if (cmd.emit_done) begin
      out_all_done      = 1'b1;
      out_last_in_frame = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= WINDOW_RESET;
      total_r     <= TOTAL_RESET;
      frame_len_r <= '0;
      nns_r       <= '0;
      count_r     <= '0;
      rem_r       <= '0;
      rd_v_r      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_WINDOW_SIZE:   win_r   <= cfg_wdata[WIN_W-1:0];
          REG_TOTAL_PACKETS: total_r <= cfg_wdata[SEQ_BITS-1:0];
          default: ;
        endcase
      end
      rem_r   <= rem_nxt;
      count_r <= count_nxt;
      nns_r   <= nns_nxt;
      rd_v_r  <= cmd.scan;
      if (cmd.commit) frame_len_r <= count_nxt;
    end
  end

endmodule

// File: rtl/selective_repeat_frame_builder_core.sv
// top level of the selective-repeat sender frame builder
// depends on srf_pkg, srf_ctrl, srf_dpath (which holds srf_ram)

// usage
//   input channel: a loss report beat (in_loss_map) is taken on a clock edge
//   with start high and busy low; bit i flags slot i of the last frame as lost
//   result channel: out_valid marks each result beat for one cycle; the
//   receiver cannot stall, every strobed beat is final
//   config channel: cfg_valid with cfg_index / cfg_wdata; cfg_ready is always
//   high, write only while busy is low
// timing
//   lost slots are found with a priority encoder and read from the slot ram
//   one per cycle, overlapped with the previous beat; fresh numbers then
//   follow one per cycle; an empty frame gives a single done beat in the
//   cycle after the scan ends
//   steps from accept: load, resend scan and reads, a final resend check,
//   then fresh numbers or the done beat, then back to idle
//   busy stays high until the last beat has gone out, and after a frame of
//   only resends also through the final resend check
// reset
//   synchronous active-low; stored frame empty, next fresh number zero,
//   window 4, total 20; slot ram contents are not cleared (never read unset)

module selective_repeat_frame_builder_core
  import srf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [LOSS_W-1:0]     in_loss_map,
  output logic                  out_valid,
  output logic [SEQ_BITS-1:0]   out_seq_number,
  output logic                  out_is_retransmit,
  output logic                  out_all_done,
  output logic                  out_last_in_frame,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  srf_cmd_t  cmd;
  srf_stat_t stat;

  // config regs take a write in any cycle
  assign cfg_ready = 1'b1;

  srf_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  srf_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_loss_map      (in_loss_map),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_seq_number   (out_seq_number),
    .out_is_retransmit(out_is_retransmit),
    .out_all_done     (out_all_done),
    .out_last_in_frame(out_last_in_frame)
  );

endmodule

// File: dv/srf_check_pkg.sv
`timescale 1ns / 1ps
// sender window predictor and result checker for the frame builder testbench
// depends on srf_pkg for widths, limits and register codes

package srf_check_pkg;
  import srf_pkg::*;

  typedef struct packed {
    logic [SEQ_BITS-1:0] seq;
    logic                re;
    logic                done;
    logic                last;
  } seq_beat_t;

  class sender_window_model;
    logic [WIN_W-1:0]    window;
    logic [SEQ_BITS-1:0] total;
    logic [SEQ_BITS-1:0] slots [MAX_WINDOW];
    int unsigned         frame_len;
    logic [NNS_W-1:0]    next_seq;
    seq_beat_t           expected_beats [$];
    int unsigned         mismatch_count;

    function new();
      window         = WINDOW_RESET;
      total          = TOTAL_RESET;
      frame_len      = 0;
      next_seq       = '0;
      mismatch_count = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WINDOW_SIZE:   window = data[WIN_W-1:0];
        REG_TOTAL_PACKETS: total  = data[SEQ_BITS-1:0];
        default: ;
      endcase
    endfunction

    // builds the next frame from one loss report and queues its beats
    function void take_loss_report(logic [LOSS_W-1:0] loss);
      int unsigned win;
      int unsigned cnt;
      seq_beat_t   b;
      cnt = 0;
      if (window == 0) win = 1;
      else if (window > MAX_WINDOW) win = MAX_WINDOW;
      else win = window;
      // lost slots first, compacted in their old order
      for (int i = 0; i < frame_len; i++) begin
        if (loss[i]) begin
          slots[cnt] = slots[i];
          b = '{seq: slots[i], re: 1'b1, done: 1'b0, last: 1'b0};
          expected_beats.push_back(b);
          cnt++;
        end
      end
      // then fresh numbers up to the window or the total
      while (cnt < win && next_seq < NNS_W'(total)) begin
        slots[cnt] = next_seq[SEQ_BITS-1:0];
        b = '{seq: next_seq[SEQ_BITS-1:0], re: 1'b0, done: 1'b0, last: 1'b0};
        expected_beats.push_back(b);
        cnt++;
        next_seq = next_seq + 1'b1;
      end
      frame_len = cnt;
      if (cnt == 0) begin
        b = '{seq: '0, re: 1'b0, done: 1'b1, last: 1'b1};
        expected_beats.push_back(b);
      end else begin
        b = expected_beats.pop_back();
        b.last = 1'b1;
        expected_beats.push_back(b);
      end
    endfunction

    function void match_beat(seq_beat_t got);
      seq_beat_t want;
      if (expected_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 50)
          $display("%0t unexpected beat: seq %0d re %0b done %0b last %0b",
                   $time, got.seq, got.re, got.done, got.last);
        return;
      end
      want = expected_beats.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 50)
          $display("%0t mismatch: expected seq %0d re %0b done %0b last %0b, got seq %0d re %0b done %0b last %0b",
                   $time, want.seq, want.re, want.done, want.last,
                   got.seq, got.re, got.done, got.last);
      end
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction
  endclass

endpackage

// File: dv/tb_selective_repeat_frame_builder_core.sv
`timescale 1ns / 1ps
// testbench top for selective_repeat_frame_builder_core: directed and random loss reports
// depends on srf_pkg and srf_check_pkg (sender window predictor and checker)

module tb_selective_repeat_frame_builder_core;
  import srf_pkg::*;
  import srf_check_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [LOSS_W-1:0]     in_loss_map;
  logic                  out_valid;
  logic [SEQ_BITS-1:0]   out_seq_number;
  logic                  out_is_retransmit;
  logic                  out_all_done;
  logic                  out_last_in_frame;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sender_window_model win_model;
  int unsigned        cycle_count = 0;
  int unsigned        random_reports;

  selective_repeat_frame_builder_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_loss_map       (in_loss_map),
    .out_valid         (out_valid),
    .out_seq_number    (out_seq_number),
    .out_is_retransmit (out_is_retransmit),
    .out_all_done      (out_all_done),
    .out_last_in_frame (out_last_in_frame),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog on a hung handshake or a missing beat
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // monitor: values read here are the ones held during the cycle that just ended,
  // so accepted reports, register writes and result beats all line up with the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready)
        win_model.set_reg(cfg_reg_t'(cfg_index), cfg_wdata);
      if (start && !busy)
        win_model.take_loss_report(in_loss_map);
      if (out_valid)
        win_model.match_beat('{seq: out_seq_number, re: out_is_retransmit,
                               done: out_all_done, last: out_last_in_frame});
    end
  end

  // offers one report beat and holds it until taken; start is left high so a
  // following beat can go out back to back
  task automatic send_report(logic [LOSS_W-1:0] loss);
    start       <= 1'b1;
    in_loss_map <= loss;
    do @(posedge clk); while (busy);
  endtask

  // drops start and waits until every expected beat is out and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (win_model.pending() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] win_data, logic [CFG_DATA_W-1:0] total_data);
    drain();
    write_reg(REG_WINDOW_SIZE, win_data);
    write_reg(REG_TOTAL_PACKETS, total_data);
    cfg_valid <= 1'b0;
  endtask

  // mostly sparse maps so frames keep advancing, with some full and empty ones
  function automatic logic [LOSS_W-1:0] pick_loss();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom & $urandom;
      4:       return $urandom;
      5:       return LOSS_W'(1) << $urandom_range(0, LOSS_W - 1);
      default: return $urandom & $urandom & $urandom;
    endcase
  endfunction

  // upper data bits above the window field are sometimes random and must be dropped
  function automatic logic [CFG_DATA_W-1:0] pick_window();
    logic [CFG_DATA_W-1:0] hi;
    hi = CFG_DATA_W'($urandom) & ~CFG_DATA_W'(6'h3f);
    if ($urandom_range(0, 3) != 0) hi = '0;
    case ($urandom_range(0, 9))
      0:       return hi | CFG_DATA_W'(0);
      1:       return hi | CFG_DATA_W'(32);
      2:       return hi | CFG_DATA_W'($urandom_range(33, 63));
      3:       return hi | CFG_DATA_W'(1);
      default: return hi | CFG_DATA_W'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_total();
    int unsigned issued;
    int unsigned t;
    issued = win_model.next_seq;
    case ($urandom_range(0, 9))
      0: t = 65535;
      1: t = (issued == 0) ? 1 : issued;
      2: t = (issued > 10) ? issued - $urandom_range(1, 10) : 1;
      3: t = $urandom_range(1, 65535);
      default: t = issued + $urandom_range(1, 300);
    endcase
    if (t > 65535) t = 65535;
    return CFG_DATA_W'(t);
  endfunction

  // bursts of random length separated by random gaps; long bursts give
  // stretches with no sender idling at all
  task automatic send_random(int unsigned n);
    int unsigned left;
    int unsigned burst;
    int unsigned gap;
    left = n;
    while (left > 0) begin
      burst = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 8);
      for (int k = 0; k < burst && left > 0; k++) begin
        send_report(pick_loss());
        left--;
        random_reports++;
      end
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    win_model      = new();
    random_reports = 0;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_loss_map <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= REG_WINDOW_SIZE;
    cfg_wdata   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: window 4, total 20; loss bits past an empty frame are ignored
    send_report('1);
    send_report('1);              // whole frame lost, window full of resends
    send_report(32'h0000_0005);   // two resends then fresh numbers
    send_report(32'hffff_fff0);   // only bits beyond the frame set
    send_report(32'h0000_0008);

    // window zero acts as one slot
    configure(16'h0000, 16'd20);
    send_report('0);
    send_report(32'h0000_0001);

    // window above the maximum saturates; full 32 slot frame
    configure(16'hffff, 16'hffff);
    send_report('0);

    // more lost slots than the new window: all resent, no fresh numbers
    configure(16'd3, 16'hffff);
    send_report('1);
    send_report(32'h8000_0001);

    // total dropped below what was already issued
    configure(16'd32, 16'd40);
    send_report(32'h0000_0007);
    send_report('0);              // nothing left: done beat
    send_report('1);              // empty stored frame again gives done

    configure(16'd5, 16'd60);
    send_report(32'haaaa_aaaa);
    send_report(32'h5555_5555);
    send_report('0);

    // random phases, each with fresh register settings
    while (random_reports < 400) begin
      configure(pick_window(), pick_total());
      send_random($urandom_range(10, 40));
    end

    drain();
    if (win_model.mismatch_count == 0 && win_model.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/srf_pkg.sv
rtl/srf_ram.sv
rtl/srf_ctrl.sv
rtl/srf_dpath.sv
rtl/selective_repeat_frame_builder_core.sv
dv/srf_check_pkg.sv
dv/tb_selective_repeat_frame_builder_core.sv
